@@ design/assert_macros.svh @@
// Assertion macros for the character LCD serializer, included by lcdr_front.
// Each macro expects clk and arst_n in scope at the point of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent holds in the same cycle as the antecedent.
`define LCDR_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define LCDR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/lcdr_pkg.sv @@
// Types and constants of the character LCD refresh serializer.
// No dependencies; imported by every module and interface of the block.
`default_nettype none
package lcdr_pkg;

	localparam int FUNC_W     = 3;
	localparam int PAGE_W     = 2;
	localparam int ROW_W      = 2;
	localparam int COL_W      = 5;
	localparam int CHAR_W     = 8;
	localparam int BYTE_W     = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = 1;
	localparam int QCNT_W      = 2;

	localparam logic [CHAR_W-1:0] CMD_CLEAR  = 8'h01;
	localparam logic [CHAR_W-1:0] CMD_HOME   = 8'h02;
	localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;

	localparam logic [CFG_IDX_W-1:0] CFG_PAGE_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BACKLIGHT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ROW_ORDER  = 2'd2;

	localparam logic [2:0] PAGE_COUNT_RST = 3'd4;
	localparam logic       BACKLIGHT_RST  = 1'b1;
	localparam logic [7:0] ROW_ORDER_RST  = 8'd216;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_WRITE = 3'd0,
		FUNC_NEXT  = 3'd1,
		FUNC_PREV  = 3'd2,
		FUNC_TICK  = 3'd3,
		FUNC_CLEAR = 3'd4
	} func_t;

	typedef enum logic [2:0] {
		FS_CLEAR,
		FS_IDLE,
		FS_CMD,
		FS_HOME,
		FS_DATA
	} front_state_t;

	typedef struct packed {
		logic [2:0] page_count;
		logic       backlight;
		logic [7:0] row_order;
	} cfg_t;

	typedef struct packed {
		logic [CHAR_W-1:0] value;
		logic              data;
		logic              last;
	} job_t;

endpackage
`default_nettype wire

@@ design/lcdr_item_if.sv @@
// Request channel of the serializer: function code and cell write fields.
// Depends on lcdr_pkg for field widths.
`default_nettype none
interface lcdr_item_if;
	import lcdr_pkg::*;

	logic              valid;
	logic              ready;
	logic [FUNC_W-1:0] func;
	logic [PAGE_W-1:0] page;
	logic [ROW_W-1:0]  row;
	logic [COL_W-1:0]  col;
	logic [CHAR_W-1:0] char_code;

	modport source (output valid, func, page, row, col, char_code, input ready);
	modport sink   (input valid, func, page, row, col, char_code, output ready);
endinterface
`default_nettype wire

@@ design/lcdr_byte_if.sv @@
// Output channel of the serializer: one expander byte per transfer.
// Depends on lcdr_pkg for field widths.
`default_nettype none
interface lcdr_byte_if;
	import lcdr_pkg::*;

	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] expander_byte;
	logic              last;

	modport source (output valid, expander_byte, last, input ready);
	modport sink   (input valid, expander_byte, last, output ready);
endinterface
`default_nettype wire

@@ design/lcdr_cfg_if.sv @@
// Configuration write channel: register index and write data.
// Depends on lcdr_pkg for field widths.
`default_nettype none
interface lcdr_cfg_if;
	import lcdr_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ design/lcdr_front.sv @@
// Front end: accepts requests, owns the cell store, page and scan state,
// and queues command and data bytes. Depends on lcdr_pkg, lcdr_item_if, assert_macros.svh.
`default_nettype none
module lcdr_front #(
	parameter int PAGES_MAX = 4,
	parameter int ROW_COUNT = 4,
	parameter int COL_COUNT = 20
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	lcdr_item_if.sink         cmd,
	input  wire lcdr_pkg::cfg_t cfg,
	output logic              push_valid,
	input  wire logic         push_ready,
	output lcdr_pkg::job_t    push_job
);
	import lcdr_pkg::*;
	`include "assert_macros.svh"

	localparam int CPP   = ROW_COUNT * COL_COUNT;
	localparam int DEPTH = PAGES_MAX * CPP;
	localparam int AW    = $clog2(DEPTH);
	localparam int PW    = (PAGES_MAX > 1) ? $clog2(PAGES_MAX) : 1;
	localparam int SW    = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
	localparam int CW    = $clog2(COL_COUNT);

	front_state_t state_q, state_d;
	logic [AW-1:0]     clr_q;
	logic [PW-1:0]     shown_q;
	logic [SW-1:0]     slot_q;
	logic [CW-1:0]     col_q;
	logic [CHAR_W-1:0] rd_q;
	logic              blank_q;
	logic [CHAR_W-1:0] mem [DEPTH];

	func_t         func;
	logic          acc;
	logic          at_zero;
	logic          wr_ok;
	logic          row_ok;
	logic [1:0]    disp_row;
	logic [31:0]   pc32;
	logic [PW:0]   pc;
	logic [PW:0]   shown_x;
	logic [PW:0]   pc_m1;
	logic [PW-1:0] next_pg;
	logic [PW-1:0] prev_pg;
	logic [31:0]   waddr32;
	logic [31:0]   raddr32;
	logic          we;
	logic [AW-1:0] waddr;
	logic [CHAR_W-1:0] wdata;

	assign func    = func_t'(cmd.func);
	assign acc     = cmd.valid && cmd.ready;
	assign at_zero = (slot_q == '0) && (col_q == '0);

	always_comb begin
		if (cfg.page_count == '0)
			pc32 = 32'd1;
		else if (32'(cfg.page_count) > 32'(PAGES_MAX))
			pc32 = 32'(PAGES_MAX);
		else
			pc32 = 32'(cfg.page_count);
	end
	assign pc      = pc32[PW:0];
	assign pc_m1   = pc - (PW+1)'(1);
	assign shown_x = {1'b0, shown_q};
	assign next_pg = ((shown_x + (PW+1)'(1)) >= pc) ? '0 : shown_q + PW'(1);
	assign prev_pg = ((shown_q == '0) || (shown_x >= pc)) ? pc_m1[PW-1:0]
		: shown_q - PW'(1);

	assign wr_ok = (32'(cmd.page) < 32'(PAGES_MAX)) && (32'(cmd.row) < 32'(ROW_COUNT))
		&& (32'(cmd.col) < 32'(COL_COUNT));
	assign waddr32 = 32'(cmd.page) * 32'(CPP) + 32'(cmd.row) * 32'(COL_COUNT)
		+ 32'(cmd.col);

	assign disp_row = 2'(cfg.row_order >> {slot_q, 1'b0});
	assign row_ok   = 32'(disp_row) < 32'(ROW_COUNT);
	assign raddr32  = 32'(shown_q) * 32'(CPP) + 32'(disp_row) * 32'(COL_COUNT)
		+ 32'(col_q);

	assign we    = (state_q == FS_CLEAR) || (acc && (func == FUNC_WRITE) && wr_ok);
	assign waddr = (state_q == FS_CLEAR) ? clr_q : waddr32[AW-1:0];
	assign wdata = (state_q == FS_CLEAR) ? '0 : cmd.char_code;

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (acc && (func == FUNC_TICK))
			rd_q <= mem[raddr32[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= FS_CLEAR;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d    = state_q;
		cmd.ready  = 1'b0;
		push_valid = 1'b0;
		push_job   = '{value: CMD_CLEAR, data: 1'b0, last: 1'b1};
		unique case (state_q)
			FS_CLEAR: begin
				if (clr_q == AW'(DEPTH - 1))
					state_d = FS_IDLE;
			end
			FS_IDLE: begin
				cmd.ready = 1'b1;
				if (cmd.valid) begin
					unique case (func)
						FUNC_WRITE: state_d = FS_IDLE;
						FUNC_NEXT, FUNC_PREV: state_d = FS_CMD;
						FUNC_TICK: state_d = at_zero ? FS_HOME : FS_DATA;
						FUNC_CLEAR: state_d = FS_CLEAR;
						default: state_d = FS_IDLE;
					endcase
				end
			end
			FS_CMD: begin
				push_valid = 1'b1;
				if (push_ready)
					state_d = FS_IDLE;
			end
			FS_HOME: begin
				push_valid = 1'b1;
				push_job   = '{value: CMD_HOME, data: 1'b0, last: 1'b0};
				if (push_ready)
					state_d = FS_DATA;
			end
			FS_DATA: begin
				push_valid = 1'b1;
				push_job   = '{value: (blank_q || rd_q == '0) ? CHAR_SPACE : rd_q,
					data: 1'b1, last: 1'b1};
				if (push_ready)
					state_d = FS_IDLE;
			end
			default: state_d = FS_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q   <= '0;
			shown_q <= '0;
			slot_q  <= '0;
			col_q   <= '0;
			blank_q <= 1'b0;
		end else begin
			if (state_q == FS_CLEAR)
				clr_q <= clr_q + AW'(1);
			if (acc) begin
				case (func)
					FUNC_NEXT: shown_q <= next_pg;
					FUNC_PREV: shown_q <= prev_pg;
					FUNC_CLEAR: clr_q <= '0;
					FUNC_TICK: begin
						blank_q <= !row_ok;
						if (col_q == CW'(COL_COUNT - 1)) begin
							col_q  <= '0;
							slot_q <= (slot_q == SW'(ROW_COUNT - 1)) ? '0 : slot_q + SW'(1);
						end else begin
							col_q <= col_q + CW'(1);
						end
					end
					default: ;
				endcase
			end
		end
	end

	`LCDR_ASSERT_NEXT(a_tick_home, acc && (func == FUNC_TICK) && at_zero,
		state_q == FS_HOME, "tick at scan start did not send home first")
	`LCDR_ASSERT_NEXT(a_clear_done, (state_q == FS_CLEAR) && (clr_q == AW'(DEPTH - 1)),
		state_q == FS_IDLE, "clear sweep did not finish")
	`LCDR_ASSERT_NEXT(a_scan_hold, !(acc && (func == FUNC_TICK)),
		$stable(col_q) && $stable(slot_q), "scan moved without a tick")
	`LCDR_ASSERT_SAME(a_home_pos, state_q == FS_HOME,
		(col_q == CW'(1)) && (slot_q == '0), "home sent away from scan start")

endmodule
`default_nettype wire

@@ design/lcdr_queue.sv @@
// Short job queue between the front end and the nibble serializer.
// Depends on lcdr_pkg for the job type and depth.
`default_nettype none
module lcdr_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push_valid,
	output logic                push_ready,
	input  wire lcdr_pkg::job_t push_job,
	output logic                pop_valid,
	input  wire logic           pop_ready,
	output lcdr_pkg::job_t      pop_job
);
	import lcdr_pkg::*;

	job_t              q_mem [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              push;
	logic              pop;

	assign push_ready = count_q != QCNT_W'(QUEUE_DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_job    = q_mem[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push)
			q_mem[wr_ptr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			if (push && !pop)
				count_q <= count_q + QCNT_W'(1);
			else if (pop && !push)
				count_q <= count_q - QCNT_W'(1);
		end
	end

endmodule
`default_nettype wire

@@ design/lcdr_back.sv @@
// Back end: splits each queued byte into two nibbles and each nibble into
// enable-high and enable-low expander bytes. Depends on lcdr_pkg, lcdr_byte_if.
`default_nettype none
module lcdr_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire lcdr_pkg::cfg_t cfg,
	input  wire logic           pop_valid,
	output logic                pop_ready,
	input  wire lcdr_pkg::job_t pop_job,
	lcdr_byte_if.source         stream
);
	import lcdr_pkg::*;

	job_t       job_q;
	logic [1:0] phase_q;
	logic       busy_q;
	logic       done;
	logic [3:0] nib;

	assign done      = stream.valid && stream.ready && (phase_q == 2'd3);
	assign pop_ready = !busy_q || done;
	assign nib       = phase_q[1] ? job_q.value[3:0] : job_q.value[7:4];

	assign stream.valid         = busy_q;
	assign stream.expander_byte = {nib, cfg.backlight, ~phase_q[0], 1'b0, job_q.data};
	assign stream.last          = job_q.last && (phase_q == 2'd3);

	always_ff @(posedge clk) begin
		if (pop_valid && pop_ready)
			job_q <= pop_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			phase_q <= '0;
		end else begin
			if (pop_valid && pop_ready) begin
				busy_q  <= 1'b1;
				phase_q <= '0;
			end else if (done) begin
				busy_q <= 1'b0;
			end else if (stream.valid && stream.ready) begin
				phase_q <= phase_q + 2'd1;
			end
		end
	end

endmodule
`default_nettype wire

@@ design/char_lcd_paged_refresh_serializer.sv @@
// Top level of the paged character LCD refresh serializer.
// Depends on lcdr_pkg, the three channel interfaces, lcdr_front,
// lcdr_queue and lcdr_back.
//
// Requests enter on cmd: write a cell, step the shown page forward or back,
// refresh tick, or clear all. Each byte sent to the LCD leaves on stream as
// four expander bytes, one per cycle while the receiver is ready; last marks
// the final expander byte of a request. cfg sets page count, backlight and
// row scan order and is always ready.
// A page step yields 4 expander bytes, a refresh tick 4, or 8 at scan start
// (home first); the serializer sustains one expander byte per cycle while the
// receiver is ready, and the tick rate is bound by the four-phase nibble
// serializer. The front end runs up to two bytes ahead through a two-entry
// queue, then drops ready until the serializer frees a queue entry; a stalled
// receiver holds the current byte. Reset and clear all sweep the cell store,
// one cell per cycle, over all PAGES_MAX*ROW_COUNT*COL_COUNT cells (320 by
// default) with cmd not ready. Reset clears page and scan position and
// restores the default configuration.
`default_nettype none
module char_lcd_paged_refresh_serializer #(
	parameter int PAGES_MAX = 4,
	parameter int ROW_COUNT = 4,
	parameter int COL_COUNT = 20
) (
	input  wire logic clk,
	input  wire logic arst_n,
	lcdr_item_if.sink   cmd,
	lcdr_byte_if.source stream,
	lcdr_cfg_if.sink    cfg
);
	import lcdr_pkg::*;

	cfg_t cfg_q;
	logic push_valid;
	logic push_ready;
	job_t push_job;
	logic pop_valid;
	logic pop_ready;
	job_t pop_job;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{page_count: PAGE_COUNT_RST, backlight: BACKLIGHT_RST,
				row_order: ROW_ORDER_RST};
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_PAGE_COUNT: cfg_q.page_count <= cfg.data[2:0];
				CFG_BACKLIGHT:  cfg_q.backlight  <= cfg.data[0];
				CFG_ROW_ORDER:  cfg_q.row_order  <= cfg.data;
				default: ;
			endcase
		end
	end

	lcdr_front #(
		.PAGES_MAX(PAGES_MAX),
		.ROW_COUNT(ROW_COUNT),
		.COL_COUNT(COL_COUNT)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cfg       (cfg_q),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_job  (push_job)
	);

	lcdr_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_job  (push_job),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_job   (pop_job)
	);

	lcdr_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready),
		.pop_job  (pop_job),
		.stream   (stream)
	);

endmodule
`default_nettype wire
